[src/artu_pkg.sv]
package artu_pkg;

  localparam int unsigned NumCols = 4;
  localparam int unsigned HalfWidth = 64;

  typedef enum logic [2:0] {
    OP_ADDKEY   = 3'd0,
    OP_SUB      = 3'd1,
    OP_SHIFT    = 3'd2,
    OP_MIX      = 3'd3,
    OP_INVSUB   = 3'd4,
    OP_INVSHIFT = 3'd5,
    OP_INVMIX   = 3'd6,
    OP_PASS     = 3'd7
  } opcode_t;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] col_t;

  function automatic byte_t xt(byte_t a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(byte_t a, byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic byte_t ginv(byte_t a);
    byte_t r;
    byte_t base;
    r = 8'h01;
    base = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) begin
        r = gmul(r, base);
      end
      base = gmul(base, base);
    end
    ginv = r;
  endfunction

  function automatic byte_t rotl8(byte_t v, int n);
    rotl8 = byte_t'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic byte_t sbox_calc(byte_t x);
    byte_t b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox_calc(byte_t s);
    inv_sbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  typedef byte_t sbox_tab_t [256];

  function automatic sbox_tab_t make_sbox(logic inv);
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(byte_t'(i)) : sbox_calc(byte_t'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_tab_t SBOX = make_sbox(1'b0);
  localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

endpackage

[src/artu_if.sv]
interface artu_in_if;
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic [63:0] state_hi;
  logic [63:0] state_lo;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  modport source (output valid, opcode, state_hi, state_lo, key_hi, key_lo, input ready);
  modport sink (input valid, opcode, state_hi, state_lo, key_hi, key_lo, output ready);
endinterface

interface artu_out_if;
  logic valid;
  logic ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

[src/artu_lane.sv]
module artu_lane (
  input  artu_pkg::opcode_t opcode,
  input  artu_pkg::col_t    col,
  input  artu_pkg::col_t    key_col,
  output artu_pkg::col_t    col_out
);

  artu_pkg::byte_t a [4];
  artu_pkg::byte_t t [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = col[31 - 8 * i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      t[i] = a[i];
    end
    unique case (opcode)
      artu_pkg::OP_ADDKEY: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = a[i] ^ key_col[31 - 8 * i -: 8];
        end
      end
      artu_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = artu_pkg::SBOX[a[i]];
        end
      end
      artu_pkg::OP_INVSUB: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = artu_pkg::INV_SBOX[a[i]];
        end
      end
      artu_pkg::OP_MIX: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = artu_pkg::xt(a[i]) ^ artu_pkg::xt(a[(i + 1) % 4]) ^ a[(i + 1) % 4]
                 ^ a[(i + 2) % 4] ^ a[(i + 3) % 4];
        end
      end
      artu_pkg::OP_INVMIX: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = artu_pkg::gmul(a[i], 8'h0e) ^ artu_pkg::gmul(a[(i + 1) % 4], 8'h0b)
                 ^ artu_pkg::gmul(a[(i + 2) % 4], 8'h0d)
                 ^ artu_pkg::gmul(a[(i + 3) % 4], 8'h09);
        end
      end
      default: begin
      end
    endcase
    col_out = {t[0], t[1], t[2], t[3]};
  end

endmodule

[src/aes_round_transform_unit_top.sv]
// Applies one AES round transform per transaction to a 128-bit state: AddRoundKey,
// (Inv)SubBytes, (Inv)ShiftRows or (Inv)MixColumns, chosen by the opcode; opcode 7
// passes the state through. A new transaction is accepted every cycle unless a stalled
// output holds the full result register; four column lanes compute in the input cycle
// and one output register holds the result, valid in the cycle after acceptance.
module aes_round_transform_unit_top (
  input logic clk,
  input logic rst,
  artu_in_if.sink    in_ch,
  artu_out_if.source out_ch
);

  artu_pkg::opcode_t opcode;
  artu_pkg::col_t    cols     [artu_pkg::NumCols];
  artu_pkg::col_t    key_cols [artu_pkg::NumCols];
  artu_pkg::col_t    lane_out [artu_pkg::NumCols];
  artu_pkg::col_t    merged   [artu_pkg::NumCols];
  logic              out_valid;
  logic [artu_pkg::HalfWidth-1:0] res_hi;
  logic [artu_pkg::HalfWidth-1:0] res_lo;
  logic              take;

  assign opcode = artu_pkg::opcode_t'(in_ch.opcode);
  assign cols[0] = in_ch.state_hi[63:32];
  assign cols[1] = in_ch.state_hi[31:0];
  assign cols[2] = in_ch.state_lo[63:32];
  assign cols[3] = in_ch.state_lo[31:0];
  assign key_cols[0] = in_ch.key_hi[63:32];
  assign key_cols[1] = in_ch.key_hi[31:0];
  assign key_cols[2] = in_ch.key_lo[63:32];
  assign key_cols[3] = in_ch.key_lo[31:0];

  for (genvar g = 0; g < artu_pkg::NumCols; g++) begin : g_lane
    artu_lane u_lane (
      .opcode  (opcode),
      .col     (cols[g]),
      .key_col (key_cols[g]),
      .col_out (lane_out[g])
    );
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      merged[c] = lane_out[c];
    end
    if (opcode == artu_pkg::OP_SHIFT || opcode == artu_pkg::OP_INVSHIFT) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (opcode == artu_pkg::OP_SHIFT) begin
            merged[c][31 - 8 * r -: 8] = cols[(c + r) % 4][31 - 8 * r -: 8];
          end else begin
            merged[c][31 - 8 * r -: 8] = cols[(c - r + 4) % 4][31 - 8 * r -: 8];
          end
        end
      end
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_hi <= {merged[0], merged[1]};
      res_lo <= {merged[2], merged[3]};
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.result_hi = res_hi;
  assign out_ch.result_lo = res_lo;

  a_take_sets_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid) else $error("accepted transaction lost");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(res_hi) && $stable(res_lo))
    else $error("stalled result changed");
  a_no_ready_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !in_ch.ready) else $error("ready while full");
  a_addkey_result: assert property (@(posedge clk) disable iff (rst)
    take && opcode == artu_pkg::OP_ADDKEY
    |=> res_hi == ($past(in_ch.state_hi) ^ $past(in_ch.key_hi)))
    else $error("addkey mismatch");

endmodule

[test/artu_tb_checker.sv]
`timescale 1ns / 100ps

module artu_tb_checker (
  input logic clk,
  input logic rst,
  artu_in_if.sink in_ch,
  artu_out_if.sink out_ch,
  output int fail_count,
  output int pending_count
);

  logic [127:0] expected_states[$];

  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] finv(logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = fmul(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rl(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] b;
    b = finv(x);
    return b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(logic [7:0] s);
    return finv(rl(s, 1) ^ rl(s, 3) ^ rl(s, 6) ^ 8'h05);
  endfunction

  logic [7:0] sub_lut[256];
  logic [7:0] inv_sub_lut[256];

  initial begin
    for (int i = 0; i < 256; i++) begin
      sub_lut[i] = fwd_sub(8'(i));
      inv_sub_lut[i] = rev_sub(8'(i));
    end
  end

  function automatic logic [127:0] transform_state(artu_pkg::opcode_t op, logic [127:0] st,
                                                   logic [127:0] key);
    logic [7:0] s[16];
    logic [7:0] k[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8 * i -: 8];
      k[i] = key[127 - 8 * i -: 8];
      t[i] = s[i];
    end
    case (op)
      artu_pkg::OP_ADDKEY: for (int i = 0; i < 16; i++) t[i] = s[i] ^ k[i];
      artu_pkg::OP_SUB: for (int i = 0; i < 16; i++) t[i] = sub_lut[s[i]];
      artu_pkg::OP_INVSUB: for (int i = 0; i < 16; i++) t[i] = inv_sub_lut[s[i]];
      artu_pkg::OP_SHIFT: for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) t[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
      artu_pkg::OP_INVSHIFT: for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) t[r + 4 * c] = s[r + 4 * ((c - r + 4) % 4)];
      artu_pkg::OP_MIX: for (int c = 0; c < 4; c++) begin
        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
        t[4 * c] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
        t[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
        t[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
        t[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
      end
      artu_pkg::OP_INVMIX: for (int c = 0; c < 4; c++) begin
        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
        t[4 * c] = fmul(a0, 8'h0e) ^ fmul(a1, 8'h0b) ^ fmul(a2, 8'h0d) ^ fmul(a3, 8'h09);
        t[4 * c + 1] = fmul(a0, 8'h09) ^ fmul(a1, 8'h0e) ^ fmul(a2, 8'h0b) ^ fmul(a3, 8'h0d);
        t[4 * c + 2] = fmul(a0, 8'h0d) ^ fmul(a1, 8'h09) ^ fmul(a2, 8'h0e) ^ fmul(a3, 8'h0b);
        t[4 * c + 3] = fmul(a0, 8'h0b) ^ fmul(a1, 8'h0d) ^ fmul(a2, 8'h09) ^ fmul(a3, 8'h0e);
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = t[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = expected_states.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected result_hi", out_ch.result_hi, '0);
        end else begin
          want = expected_states.pop_front();
          if (out_ch.result_hi !== want[127:64])
            report_mismatch("result_hi", out_ch.result_hi, want[127:64]);
          if (out_ch.result_lo !== want[63:0])
            report_mismatch("result_lo", out_ch.result_lo, want[63:0]);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_states.push_back(transform_state(artu_pkg::opcode_t'(in_ch.opcode),
            {in_ch.state_hi, in_ch.state_lo}, {in_ch.key_hi, in_ch.key_lo}));
    end
  end
endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int NumRandom = 830;
  localparam int IdleLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  artu_in_if in_ch();
  artu_out_if out_ch();

  aes_round_transform_unit_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  artu_tb_checker checker_i (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                             .fail_count(fail_count), .pending_count(pending_count));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8080_8080_8080_8080;
      3: return 64'h0101_0101_0101_0101;
      default: return rand64();
    endcase
  endfunction

  task automatic send_transaction(artu_pkg::opcode_t op, logic [63:0] sh, logic [63:0] sl,
                                  logic [63:0] kh, logic [63:0] kl);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.state_hi <= sh;
    in_ch.state_lo <= sl;
    in_ch.key_hi <= kh;
    in_ch.key_lo <= kl;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic go_idle(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("** aes_round_transform_unit_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int mode;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (40) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 12)) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 3) != 0;
          2: out_ch.ready <= $urandom_range(0, 3) < 2;
          default: out_ch.ready <= $urandom_range(0, 3) == 0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    artu_pkg::opcode_t op;
    in_ch.valid = 1'b0;
    in_ch.opcode = artu_pkg::OP_ADDKEY;
    in_ch.state_hi = '0;
    in_ch.state_lo = '0;
    in_ch.key_hi = '0;
    in_ch.key_lo = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_transaction(artu_pkg::OP_ADDKEY, '0, '0, '1, '1);
    send_transaction(artu_pkg::OP_ADDKEY, '1, '1, '1, '1);
    send_transaction(artu_pkg::OP_ADDKEY, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
                     64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    for (int i = 0; i < 8; i++) begin
      op = artu_pkg::opcode_t'(i);
      send_transaction(op, '0, '0, rand64(), rand64());
      send_transaction(op, '1, '1, rand64(), rand64());
      send_transaction(op, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                       rand64(), rand64());
    end

    long_hold = 1'b1;
    repeat (30) send_transaction(artu_pkg::opcode_t'($urandom_range(0, 7)), rand64(),
                                 rand64(), rand64(), rand64());

    for (int n = 0; n < NumRandom; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && n < NumRandom; j++, n++)
        send_transaction(artu_pkg::opcode_t'($urandom_range(0, 7)), edge64(), edge64(),
                         edge64(), edge64());
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
    end
    go_idle(0);

    while (pending_count != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("** aes_round_transform_unit_top: PASSED **");
    end else begin
      $display("** aes_round_transform_unit_top: FAILED **");
    end
    $finish;
  end
endmodule
